### sv/ctm_pkg.sv
// ----------------------------------------------------------------------------
// ctm_pkg - shared types and constants of the cs tag mutation parser
// Character codes, operation classes, result kinds and the queued item.
// ----------------------------------------------------------------------------
package ctm_pkg;

   // operation and digit characters of the difference string
   localparam logic [7:0] CH_STAR  = 8'h2A;   // '*' substitution
   localparam logic [7:0] CH_PLUS  = 8'h2B;   // '+' insertion
   localparam logic [7:0] CH_MINUS = 8'h2D;   // '-' deletion
   localparam logic [7:0] CH_COLON = 8'h3A;   // ':' match count
   localparam logic [7:0] CH_EQUAL = 8'h3D;   // '=' long match, skipped
   localparam logic [7:0] CH_TILDE = 8'h7E;   // '~' intron, skipped
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // operation class found by the front end
   localparam logic [2:0] OP_NONE  = 3'd0;
   localparam logic [2:0] OP_MATCH = 3'd1;
   localparam logic [2:0] OP_SUB   = 3'd2;
   localparam logic [2:0] OP_INS   = 3'd3;
   localparam logic [2:0] OP_DEL   = 3'd4;
   localparam logic [2:0] OP_SKIP  = 3'd5;

   // result kinds
   localparam logic [1:0] KIND_SUB = 2'd0;
   localparam logic [1:0] KIND_INS = 2'd1;
   localparam logic [1:0] KIND_DEL = 2'd2;

   localparam logic [31:0] POS_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [7:0]  ch;
      logic        starts_string;
      logic [31:0] start_pos;
      logic [2:0]  op;
      logic        is_digit;
      logic [3:0]  digit;
   } ctm_item_type;

endpackage

### sv/ctm_req_if.sv
// ----------------------------------------------------------------------------
// ctm_req_if - character channel into the parser
// One character of the difference string per item, with string start marker.
// ----------------------------------------------------------------------------
interface ctm_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  ch;
   logic        starts_string;
   logic [31:0] start_pos;

   modport source (output valid, ch, starts_string, start_pos, input ready);
   modport sink   (input valid, ch, starts_string, start_pos, output ready);
endinterface

### sv/ctm_rsp_if.sv
// ----------------------------------------------------------------------------
// ctm_rsp_if - mutation result channel out of the parser
// One mutated base (or one error mark) per item.
// ----------------------------------------------------------------------------
interface ctm_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] mut_pos;
   logic [7:0]  base;
   logic [7:0]  ref_char;
   logic        first_base;
   logic        error;

   modport source (output valid, kind, mut_pos, base, ref_char, first_base, error,
                   input ready);
   modport sink   (input valid, kind, mut_pos, base, ref_char, first_base, error,
                   output ready);
endinterface

### sv/ctm_front.sv
// ----------------------------------------------------------------------------
// ctm_front - character classifier
// Tags each character with its operation class and decimal digit value.
// ----------------------------------------------------------------------------
module ctm_front (
   input  logic [7:0]            ch,
   input  logic                  starts_string,
   input  logic [31:0]           start_pos,
   output ctm_pkg::ctm_item_type item
);

   logic [7:0] digit_w;

   assign digit_w = ch - ctm_pkg::CH_ZERO;

   always_comb begin
      item               = '0;
      item.ch            = ch;
      item.starts_string = starts_string;
      item.start_pos     = start_pos;
      item.is_digit      = (ch >= ctm_pkg::CH_ZERO) && (ch <= ctm_pkg::CH_NINE);
      item.digit         = digit_w[3:0];
      unique case (ch)
         ctm_pkg::CH_COLON: item.op = ctm_pkg::OP_MATCH;
         ctm_pkg::CH_STAR:  item.op = ctm_pkg::OP_SUB;
         ctm_pkg::CH_PLUS:  item.op = ctm_pkg::OP_INS;
         ctm_pkg::CH_MINUS: item.op = ctm_pkg::OP_DEL;
         ctm_pkg::CH_EQUAL,
         ctm_pkg::CH_TILDE: item.op = ctm_pkg::OP_SKIP;
         default:           item.op = ctm_pkg::OP_NONE;
      endcase
   end

endmodule

### sv/ctm_queue.sv
// ----------------------------------------------------------------------------
// ctm_queue - classified item queue
// Small circular buffer between classifier and parser; push and pop can happen in the same cycle.
// ----------------------------------------------------------------------------
module ctm_queue #(
   parameter int Depth = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  ctm_pkg::ctm_item_type push_item,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output ctm_pkg::ctm_item_type pop_item
);

   localparam int PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountWidth = $clog2(Depth + 1);

   ctm_pkg::ctm_item_type slot_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  push, pop;

   assign push_ready = (count_ff != CountWidth'(Depth));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(Depth))
      else $error("queue holds more items than it has slots");

   a_pointer_gap : assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) || (count_ff == CountWidth'(Depth)) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with fill count");

endmodule

### sv/ctm_back.sv
// ----------------------------------------------------------------------------
// ctm_back - difference string parser and result register
// Tracks reference position and segment mode, one item per cycle if not stalled.
// ----------------------------------------------------------------------------
module ctm_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   output logic                  item_ready,
   input  ctm_pkg::ctm_item_type item,
   ctm_rsp_if.source             rsp_chan
);

   localparam logic [2:0] MODE_SKIP     = 3'd0;
   localparam logic [2:0] MODE_MATCH    = 3'd1;
   localparam logic [2:0] MODE_SUB_REF  = 3'd2;
   localparam logic [2:0] MODE_SUB_QRY  = 3'd3;
   localparam logic [2:0] MODE_SUB_DONE = 3'd4;
   localparam logic [2:0] MODE_INS      = 3'd5;
   localparam logic [2:0] MODE_DEL      = 3'd6;

   logic [2:0]  mode_ff, mode_in;
   logic [31:0] cur_pos_ff, cur_pos_in;
   logic [31:0] match_count_ff, match_count_in;
   logic [31:0] record_pos_ff, record_pos_in;
   logic [7:0]  held_ref_ff, held_ref_in;
   logic        run_started_ff, run_started_in;

   logic        emit;
   logic [1:0]  res_kind;
   logic [31:0] res_pos;
   logic [7:0]  res_base, res_ref;
   logic        res_first, res_err;

   logic        rsp_valid_ff;
   logic [1:0]  kind_ff;
   logic [31:0] mut_pos_ff;
   logic [7:0]  base_ff, ref_char_ff;
   logic        first_base_ff, error_ff;

   logic        pop;

   assign item_ready = !rsp_valid_ff || rsp_chan.ready;
   assign pop        = item_valid && item_ready;

   always_comb begin
      logic [32:0] sum_w;
      logic [35:0] mac_w;
      sum_w          = '0;
      mac_w          = '0;
      mode_in        = mode_ff;
      cur_pos_in     = cur_pos_ff;
      match_count_in = match_count_ff;
      record_pos_in  = record_pos_ff;
      held_ref_in    = held_ref_ff;
      run_started_in = run_started_ff;
      emit           = 1'b0;
      res_kind       = ctm_pkg::KIND_SUB;
      res_pos        = record_pos_ff;
      res_base       = '0;
      res_ref        = '0;
      res_first      = 1'b0;
      res_err        = 1'b0;

      // new string: an open short substitution is flagged, then state restarts
      if (item.starts_string) begin
         if ((mode_ff == MODE_SUB_REF) || (mode_ff == MODE_SUB_QRY)) begin
            emit      = 1'b1;
            res_pos   = record_pos_ff;
            res_first = 1'b1;
            res_err   = 1'b1;
         end
         mode_in        = MODE_SKIP;
         cur_pos_in     = item.start_pos;
         match_count_in = '0;
         record_pos_in  = item.start_pos;
         held_ref_in    = '0;
         run_started_in = 1'b0;
      end

      if (item.op != ctm_pkg::OP_NONE) begin
         // segment boundary: commit match run or flag a short substitution
         if (mode_in == MODE_MATCH) begin
            sum_w      = {1'b0, cur_pos_in} + {1'b0, match_count_in};
            cur_pos_in = sum_w[32] ? ctm_pkg::POS_MAX : sum_w[31:0];
         end else if ((mode_in == MODE_SUB_REF) || (mode_in == MODE_SUB_QRY)) begin
            emit      = 1'b1;
            res_pos   = record_pos_in;
            res_first = 1'b1;
            res_err   = 1'b1;
         end
         match_count_in = '0;
         record_pos_in  = cur_pos_in;
         held_ref_in    = '0;
         run_started_in = 1'b0;
         unique case (item.op)
            ctm_pkg::OP_MATCH: mode_in = MODE_MATCH;
            ctm_pkg::OP_SUB:   mode_in = MODE_SUB_REF;
            ctm_pkg::OP_INS:   mode_in = MODE_INS;
            ctm_pkg::OP_DEL:   mode_in = MODE_DEL;
            default:           mode_in = MODE_SKIP;
         endcase
      end else begin
         unique case (mode_in)
            MODE_MATCH: begin
               if (item.is_digit) begin
                  // count * 10 + digit, saturating
                  mac_w = ({4'b0, match_count_in} << 3) + ({4'b0, match_count_in} << 1)
                        + {32'b0, item.digit};
                  match_count_in = (mac_w[35:32] != '0) ? ctm_pkg::POS_MAX : mac_w[31:0];
               end
            end
            MODE_SUB_REF: begin
               held_ref_in = item.ch;
               mode_in     = MODE_SUB_QRY;
            end
            MODE_SUB_QRY: begin
               emit       = 1'b1;
               res_kind   = ctm_pkg::KIND_SUB;
               res_pos    = record_pos_in;
               res_base   = item.ch;
               res_ref    = held_ref_in;
               res_first  = 1'b1;
               cur_pos_in = (cur_pos_in == ctm_pkg::POS_MAX) ? cur_pos_in : cur_pos_in + 1'b1;
               mode_in    = MODE_SUB_DONE;
            end
            MODE_SUB_DONE: begin
               // third base of a substitution
               emit      = 1'b1;
               res_pos   = record_pos_in;
               res_first = 1'b1;
               res_err   = 1'b1;
               mode_in   = MODE_SKIP;
            end
            MODE_INS: begin
               emit           = 1'b1;
               res_kind       = ctm_pkg::KIND_INS;
               res_pos        = record_pos_in;
               res_base       = item.ch;
               res_first      = !run_started_in;
               run_started_in = 1'b1;
            end
            MODE_DEL: begin
               emit           = 1'b1;
               res_kind       = ctm_pkg::KIND_DEL;
               res_pos        = record_pos_in;
               res_base       = item.ch;
               res_first      = !run_started_in;
               run_started_in = 1'b1;
               cur_pos_in = (cur_pos_in == ctm_pkg::POS_MAX) ? cur_pos_in : cur_pos_in + 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_SKIP;
         cur_pos_ff     <= '0;
         match_count_ff <= '0;
         record_pos_ff  <= '0;
         held_ref_ff    <= '0;
         run_started_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (pop) begin
            mode_ff        <= mode_in;
            cur_pos_ff     <= cur_pos_in;
            match_count_ff <= match_count_in;
            record_pos_ff  <= record_pos_in;
            held_ref_ff    <= held_ref_in;
            run_started_ff <= run_started_in;
         end
         if (item_ready) begin
            rsp_valid_ff <= pop && emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         kind_ff       <= res_kind;
         mut_pos_ff    <= res_pos;
         base_ff       <= res_base;
         ref_char_ff   <= res_ref;
         first_base_ff <= res_first;
         error_ff      <= res_err;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.kind       = kind_ff;
   assign rsp_chan.mut_pos    = mut_pos_ff;
   assign rsp_chan.base       = base_ff;
   assign rsp_chan.ref_char   = ref_char_ff;
   assign rsp_chan.first_base = first_base_ff;
   assign rsp_chan.error      = error_ff;

   a_error_shape : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && error_ff |->
         (kind_ff == ctm_pkg::KIND_SUB) && first_base_ff && (base_ff == '0)
         && (ref_char_ff == '0))
      else $error("error result with substitution fields set");

   a_del_advance : assert property (@(posedge clock) disable iff (reset)
      pop && !item.starts_string && (item.op == ctm_pkg::OP_NONE)
         && (mode_ff == MODE_DEL) && (cur_pos_ff != ctm_pkg::POS_MAX)
      |=> cur_pos_ff == $past(cur_pos_ff) + 32'd1)
      else $error("deleted base did not advance the position");

   a_no_result_while_skipping : assert property (@(posedge clock) disable iff (reset)
      pop && !item.starts_string && (item.op == ctm_pkg::OP_NONE)
         && ((mode_ff == MODE_SKIP) || (mode_ff == MODE_MATCH))
      |=> !rsp_valid_ff)
      else $error("result produced inside a match or skipped segment");

endmodule

### sv/cs_tag_mutation_parser.sv
// ----------------------------------------------------------------------------
// cs_tag_mutation_parser - cs tag difference string to per-base mutations
// Classifier, item queue and parser with a registered result stage.
// ----------------------------------------------------------------------------
//
//  port       dir   handshake        item
//  ---------  ----  ---------------  -----------------------------------------
//  req_chan   in    valid / ready    ch, starts_string, start_pos
//  rsp_chan   out   valid / ready    kind, mut_pos, base, ref_char,
//                                    first_base, error
//
// One character per cycle sustained while results are taken. A character
// is classified as it is taken and queued in a slot; the parser retires
// one queued item per cycle into the result register while that register
// is free or draining. The result handshake sets the rate.
// Reset (synchronous, active high) empties the queue, drops any pending
// result and puts the parser in skip mode at position zero.
// A stalled result holds the parser; input keeps flowing until the queue
// (QUEUE_DEPTH items) is full. Characters that give no result still pass
// through the parser while the result register is free or being drained.
// ----------------------------------------------------------------------------
module cs_tag_mutation_parser #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   ctm_req_if.sink   req_chan,
   ctm_rsp_if.source rsp_chan
);

   ctm_pkg::ctm_item_type classified;   // item as tagged by the classifier
   ctm_pkg::ctm_item_type queued;       // head of queue into the parser
   logic                  q_push_ready;
   logic                  q_pop_valid;
   logic                  q_pop_ready;

   // classify the character on its way into the queue
   ctm_front u_front (
      .ch            (req_chan.ch),
      .starts_string (req_chan.starts_string),
      .start_pos     (req_chan.start_pos),
      .item          (classified)
   );

   assign req_chan.ready = q_push_ready;

   // decouples intake from a stalled result sink
   ctm_queue #(
      .Depth (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_chan.valid),
      .push_ready (q_push_ready),
      .push_item  (classified),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_item   (queued)
   );

   // parser state and result register
   ctm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (q_pop_valid),
      .item_ready (q_pop_ready),
      .item       (queued),
      .rsp_chan   (rsp_chan)
   );

endmodule
